/* sv/rtpd_pkg.sv */
// Shared types and constants of the RTP H.264 depacketizer.
package rtpd_pkg;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ABANDON = 2'd2,
    KIND_REPORT  = 2'd3
  } kind_t;

  // Class of the packet in progress
  typedef enum logic [1:0] {
    CLS_IDLE   = 2'd0,
    CLS_SINGLE = 2'd1,
    CLS_FRAG   = 2'd2,
    CLS_DROP   = 2'd3
  } cls_t;

  // Packet report codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FAIL  = 3'd1;
  localparam logic [2:0] ST_GAP   = 3'd2;
  localparam logic [2:0] ST_STALE = 3'd3;
  localparam logic [2:0] ST_UNSUP = 3'd4;

  // NAL header fields
  localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
  localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_FU_A       = 5'd28;

  // Start code bytes
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // Result slots of one queue entry, sent lowest first
  localparam int unsigned NUM_SLOTS    = 8;
  localparam logic [2:0]  SLOT_ABANDON = 3'd0;
  localparam logic [2:0]  SLOT_SC_ONE  = 3'd4;
  localparam logic [2:0]  SLOT_BYTE    = 3'd5;
  localparam logic [2:0]  SLOT_DONE    = 3'd6;
  localparam logic [2:0]  SLOT_REPORT  = 3'd7;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // All results caused by one input word
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [31:0]          abn_time;
    logic [7:0]           data;
    logic [31:0]          unit_time;
    logic [2:0]           status;
  } entry_t;

endpackage

/* sv/rtpd_front.sv */
// Front end: per-word packet parsing, sequence check and unit tracking.
module rtpd_front #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_seq_num,
  input  logic [31:0]           in_rtp_time,
  input  logic [7:0]            in_payload_byte,
  input  logic                  in_byte_present,
  input  logic                  in_first_of_packet,
  input  logic                  in_last_of_packet,
  input  logic                  q_full,
  output logic                  q_push,
  output rtpd_pkg::entry_t      q_entry
);
  import rtpd_pkg::*;

  logic [SEQ_BITS-1:0] exp_r, exp_nxt;
  logic                known_r, known_nxt;
  logic                open_r, open_nxt;
  logic [7:0]          ind_r, ind_nxt;
  logic [4:0]          ftype_r, ftype_nxt;
  logic [31:0]         held_r, held_nxt;
  logic [1:0]          pos_r, pos_nxt;
  cls_t                cls_r, cls_nxt;
  logic [2:0]          pend_r, pend_nxt;
  logic                fend_r, fend_nxt;

  logic                accept;
  logic                abn, start, dat, cmp, rep;
  logic [7:0]          data;
  logic [2:0]          status, st_loc;
  logic [SEQ_BITS-1:0] seq_ext, diff;
  logic                gap, stale, run_last;
  logic [4:0]          ty;

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;
  assign seq_ext  = SEQ_BITS'(in_seq_num);
  assign diff     = seq_ext - exp_r;
  assign ty       = in_payload_byte[4:0];

  always_comb begin
    exp_nxt   = exp_r;
    known_nxt = known_r;
    open_nxt  = open_r;
    ind_nxt   = ind_r;
    ftype_nxt = ftype_r;
    held_nxt  = held_r;
    pos_nxt   = pos_r;
    cls_nxt   = cls_r;
    pend_nxt  = pend_r;
    fend_nxt  = fend_r;
    abn       = 1'b0;
    start     = 1'b0;
    dat       = 1'b0;
    cmp       = 1'b0;
    rep       = 1'b0;
    data      = in_payload_byte;
    status    = ST_OK;
    st_loc    = ST_OK;
    gap       = 1'b0;
    stale     = 1'b0;
    run_last  = 1'b0;

    if (in_first_of_packet) begin
      // a new first word cuts any packet in progress
      if (cls_r == CLS_SINGLE && open_nxt) begin
        abn      = 1'b1;
        open_nxt = 1'b0;
        fend_nxt = 1'b0;
      end
      cls_nxt = CLS_IDLE;
      pos_nxt = 2'd0;
      if (!in_byte_present) begin
        // empty packet
        if (open_nxt) begin
          abn      = 1'b1;
          open_nxt = 1'b0;
          fend_nxt = 1'b0;
        end
        exp_nxt  = exp_r + SEQ_BITS'(1);
        pend_nxt = ST_OK;
        rep      = 1'b1;
        status   = ST_FAIL;
      end else begin
        run_last = 1'b1;
        pos_nxt  = 2'd1;
        if (in_payload_byte[7]) begin
          // forbidden bit set
          if (open_nxt) begin
            abn      = 1'b1;
            open_nxt = 1'b0;
            fend_nxt = 1'b0;
          end
          exp_nxt  = exp_r + SEQ_BITS'(1);
          pend_nxt = ST_FAIL;
          cls_nxt  = CLS_DROP;
        end else begin
          stale = known_r && (diff != '0) && diff[SEQ_BITS-1];
          gap   = known_r && (diff != '0) && !diff[SEQ_BITS-1];
          if (stale) begin
            pend_nxt = ST_STALE;
            cls_nxt  = CLS_DROP;
          end else begin
            known_nxt = 1'b1;
            if (gap && open_nxt) begin
              abn      = 1'b1;
              open_nxt = 1'b0;
              fend_nxt = 1'b0;
            end
            exp_nxt = seq_ext + SEQ_BITS'(1);
            if (ty >= NAL_SINGLE_MIN && ty <= NAL_SINGLE_MAX) begin
              if (open_nxt) begin
                abn      = 1'b1;
                open_nxt = 1'b0;
                fend_nxt = 1'b0;
                st_loc   = ST_FAIL;
              end
              held_nxt = in_rtp_time;
              open_nxt = 1'b1;
              start    = 1'b1;
              cls_nxt  = CLS_SINGLE;
            end else if (ty == NAL_FU_A) begin
              if (open_nxt && (in_payload_byte != ind_r || in_last_of_packet)) begin
                abn      = 1'b1;
                open_nxt = 1'b0;
                fend_nxt = 1'b0;
                st_loc   = ST_FAIL;
              end
              if (in_last_of_packet) begin
                st_loc  = ST_FAIL;
                cls_nxt = CLS_DROP;
              end else begin
                if (!open_nxt) ind_nxt = in_payload_byte;
                cls_nxt = CLS_FRAG;
              end
            end else begin
              if (open_nxt) begin
                abn      = 1'b1;
                open_nxt = 1'b0;
                fend_nxt = 1'b0;
                st_loc   = ST_FAIL;
              end else begin
                st_loc = ST_UNSUP;
              end
              cls_nxt = CLS_DROP;
            end
            if (gap) st_loc = ST_GAP;
            pend_nxt = st_loc;
          end
        end
      end
    end else if (in_byte_present && cls_r != CLS_IDLE) begin
      run_last = 1'b1;
      if (cls_r == CLS_SINGLE) begin
        dat = 1'b1;
      end else if (cls_r == CLS_FRAG) begin
        if (pos_r == 2'd1) begin
          // FU header
          if (open_r && ty == ftype_r && !in_payload_byte[7]) begin
            fend_nxt = in_payload_byte[6];
          end else begin
            if (open_r) begin
              abn      = 1'b1;
              open_nxt = 1'b0;
              fend_nxt = 1'b0;
              if (pend_nxt != ST_GAP) pend_nxt = ST_FAIL;
            end
            if (in_payload_byte[7]) begin
              ftype_nxt = ty;
              held_nxt  = in_rtp_time;
              open_nxt  = 1'b1;
              fend_nxt  = in_payload_byte[6];
              start     = 1'b1;
              data      = {1'b0, ind_r[6:5], ty};
            end else begin
              if (pend_nxt != ST_GAP) pend_nxt = ST_FAIL;
              cls_nxt = CLS_DROP;
            end
          end
        end else if (open_r) begin
          dat = 1'b1;
        end
      end
      if (pos_r < 2'd2) pos_nxt = pos_r + 2'd1;
    end

    if (run_last && in_last_of_packet && cls_nxt != CLS_IDLE) begin
      if (cls_nxt == CLS_SINGLE) begin
        cmp      = 1'b1;
        open_nxt = 1'b0;
      end else if (cls_nxt == CLS_FRAG && open_nxt && fend_nxt) begin
        cmp      = 1'b1;
        open_nxt = 1'b0;
        fend_nxt = 1'b0;
      end
      rep      = 1'b1;
      status   = pend_nxt;
      cls_nxt  = CLS_IDLE;
      pos_nxt  = 2'd0;
      pend_nxt = ST_OK;
    end
  end

  always_comb begin
    q_entry.slots     = {rep, cmp, start | dat, {4{start}}, abn};
    q_entry.abn_time  = held_r;
    q_entry.data      = data;
    q_entry.unit_time = held_nxt;
    q_entry.status    = status;
    q_push            = accept && (abn || start || dat || cmp || rep);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= '0;
      known_r <= 1'b0;
      open_r  <= 1'b0;
      ind_r   <= '0;
      ftype_r <= '0;
      held_r  <= '0;
      pos_r   <= 2'd0;
      cls_r   <= CLS_IDLE;
      pend_r  <= ST_OK;
      fend_r  <= 1'b0;
    end else if (accept) begin
      exp_r   <= exp_nxt;
      known_r <= known_nxt;
      open_r  <= open_nxt;
      ind_r   <= ind_nxt;
      ftype_r <= ftype_nxt;
      held_r  <= held_nxt;
      pos_r   <= pos_nxt;
      cls_r   <= cls_nxt;
      pend_r  <= pend_nxt;
      fend_r  <= fend_nxt;
    end
  end

endmodule

/* sv/rtpd_queue.sv */
// Small entry queue between the front end and the result sequencer.
module rtpd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rtpd_pkg::entry_t wr_entry,
  input  logic             pop,
  output rtpd_pkg::entry_t rd_entry,
  output logic             full,
  output logic             empty
);
  import rtpd_pkg::*;

  entry_t             buf_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign rd_entry = buf_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (QUEUE_AW+1)'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - (QUEUE_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) buf_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* sv/rtpd_back.sv */
// Back end: expands queue entries into result words, one per cycle unless stalled.
module rtpd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rtpd_pkg::entry_t q_entry,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_byte,
  output logic [31:0]      out_unit_time,
  output logic [2:0]       out_packet_status
);
  import rtpd_pkg::*;

  entry_t               cur_r, cur_nxt;
  logic [NUM_SLOTS-1:0] rem_r, rem_nxt, low;
  logic [2:0]           slot;
  logic                 advance, last_one;

  logic                 vld_r, vld_nxt;
  kind_t                kind_r, kind_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [31:0]          time_r, time_nxt;
  logic [2:0]           st_r, st_nxt;

  assign advance  = !vld_r || !out_stall;
  assign low      = rem_r & (~rem_r + NUM_SLOTS'(1));
  assign last_one = (rem_r == low);
  assign q_pop    = !q_empty && ((rem_r == '0) || (advance && last_one));

  always_comb begin
    slot = SLOT_ABANDON;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem_r[i]) slot = 3'(i);
    end
  end

  always_comb begin
    cur_nxt  = cur_r;
    rem_nxt  = rem_r;
    vld_nxt  = vld_r;
    kind_nxt = kind_r;
    byte_nxt = byte_r;
    time_nxt = time_r;
    st_nxt   = st_r;

    if (advance) begin
      vld_nxt = (rem_r != '0);
      rem_nxt = rem_r & ~low;
      byte_nxt = SC_ZERO;
      time_nxt = cur_r.unit_time;
      st_nxt   = ST_OK;
      case (slot)
        SLOT_ABANDON: begin
          kind_nxt = KIND_ABANDON;
          time_nxt = cur_r.abn_time;
        end
        SLOT_SC_ONE: begin
          kind_nxt = KIND_DATA;
          byte_nxt = SC_ONE;
        end
        SLOT_BYTE: begin
          kind_nxt = KIND_DATA;
          byte_nxt = cur_r.data;
        end
        SLOT_DONE: begin
          kind_nxt = KIND_DONE;
        end
        SLOT_REPORT: begin
          kind_nxt = KIND_REPORT;
          st_nxt   = cur_r.status;
        end
        default: begin
          kind_nxt = KIND_DATA;
        end
      endcase
    end

    if (q_pop) begin
      cur_nxt = q_entry;
      rem_nxt = q_entry.slots;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    time_r <= time_nxt;
    st_r   <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      vld_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_valid         = vld_r;
  assign out_result_kind   = kind_r;
  assign out_byte          = byte_r;
  assign out_unit_time     = time_r;
  assign out_packet_status = st_r;

endmodule

/* sv/rtp_h264_nal_depacketizer.sv */
// Top level of the RTP H.264 depacketizer (single NAL and FU-A to Annex-B).
//
// Usage:
//  - Input channel: one RTP payload byte per word, tagged with the packet's
//    sequence number, timestamp and first/last flags. A word is taken when
//    in_valid is high and in_stall is low.
//  - Output channel: one result per word: an Annex-B byte, unit complete,
//    unit abandoned or a packet report, each with the unit's timestamp.
//    A result is taken when out_valid is high and out_stall is low.
//  - The front end parses each word in the cycle it is taken and pushes the
//    results it causes (up to eight) as one entry into a 4-entry queue.
//    The back end expands entries, one result word per cycle while not stalled.
//  - Throughput: one input word per cycle while each word causes at most one
//    result and out_stall is low; a packet start or FU header causes up to
//    eight results, one per cycle, so the result port sets the sustained rate.
//  - A result is registered in the queue, the current entry and the output.
//  - in_stall rises only when the queue is full; an output stall therefore
//    backs up through the queue before the input is held.
//  - Reset (rst_n low, synchronous) clears sequence, unit and packet state
//    and empties the queue; no results are pending afterwards.
module rtp_h264_nal_depacketizer #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_seq_num,
  input  logic [31:0] in_rtp_time,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_byte_present,
  input  logic        in_first_of_packet,
  input  logic        in_last_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] out_unit_time,
  output logic [2:0]  out_packet_status
);
  import rtpd_pkg::*;

  entry_t push_entry, head_entry;
  logic   q_push, q_pop, q_full, q_empty;

  // parse, sequence check, unit tracking
  rtpd_front #(
    .SEQ_BITS (SEQ_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_seq_num         (in_seq_num),
    .in_rtp_time        (in_rtp_time),
    .in_payload_byte    (in_payload_byte),
    .in_byte_present    (in_byte_present),
    .in_first_of_packet (in_first_of_packet),
    .in_last_of_packet  (in_last_of_packet),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_entry            (push_entry)
  );

  // decoupling queue
  rtpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (push_entry),
    .pop      (q_pop),
    .rd_entry (head_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  // result sequencer with output register
  rtpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_entry           (head_entry),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_byte          (out_byte),
    .out_unit_time     (out_unit_time),
    .out_packet_status (out_packet_status)
  );

endmodule
